/* src/sem_pkg.sv */
package sem_pkg;

    localparam int unsigned MAX_WIDTH_DEFAULT = 1024;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned GRAY_W   = 16;
    localparam int unsigned ROW_W    = 16;
    localparam int unsigned OUT_COL_W = 10;
    localparam int unsigned IMG_W_W  = 11;
    localparam int unsigned CHAN_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Sobel sums reach 4 * 65280 in magnitude: 18 bits plus sign.
    localparam int unsigned ABS_W  = 18;
    localparam int unsigned SQ_W   = 2 * ABS_W;
    localparam int unsigned RAD_W  = 38;
    localparam int unsigned ROOT_W = RAD_W / 2;
    localparam int unsigned REM_W  = ROOT_W + 2;
    localparam int unsigned STEP_W = 5;
    localparam int unsigned ROOT_STEPS = ROOT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET    = 11'd640;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET   = 16'd480;
    localparam logic [CHAN_W-1:0]  CHANNELS_RESET = 3'd3;

    localparam logic [GRAY_W-1:0] W_RED   = 16'd77;
    localparam logic [GRAY_W-1:0] W_GREEN = 16'd150;
    localparam logic [GRAY_W-1:0] W_BLUE  = 16'd29;

    typedef struct packed {
        logic [PIX_W-1:0] chan0;
        logic [PIX_W-1:0] chan1;
        logic [PIX_W-1:0] chan2;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]     magnitude;
        logic [OUT_COL_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 last;
    } pix_out_t;

    typedef struct packed {
        logic accept;
        logic calc;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic interior;
    } status_t;

endpackage

/* src/sem_datapath.sv */
module sem_datapath import sem_pkg::*; #(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  pix_in_t               pixel,
    input  cmd_t                  cmd,
    output status_t               status,
    output pix_out_t              result
);

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WU_W  = COL_W + 1;

    logic [IMG_W_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    logic [CHAN_W-1:0]  chans_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;

    logic [GRAY_W-1:0] line_one [MAX_WIDTH];
    logic [GRAY_W-1:0] line_two [MAX_WIDTH];
    logic [GRAY_W-1:0] win_reg [6];
    logic [GRAY_W-1:0] gray_reg, rd_one_reg, rd_two_reg;

    logic [ABS_W-1:0]  ax_reg, ay_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [COL_W-1:0]  ccol_reg;
    logic [ROW_W-1:0]  crow_reg;
    logic              last_reg;
    pix_out_t          result_reg;

    logic [WU_W-1:0]   w_used;
    logic [ROW_W-1:0]  h_used;
    logic [GRAY_W-1:0] gray;
    logic              last_col, last_row;
    logic signed [ABS_W:0] sx, sy;
    logic [ABS_W:0]    tr, mr, br, tl, ml, bl, tc, bc;
    logic [REM_W+1:0]  rem_sh, trial;
    logic [ROOT_W-9:0] mag_wide;
    logic [ABS_W-1:0]  sq_in;
    logic [SQ_W-1:0]   sq;

    always_comb
    begin
        if ({21'd0, width_reg} < 32'd3)
            w_used = WU_W'(3);
        else if ({21'd0, width_reg} > MAX_WIDTH)
            w_used = WU_W'(MAX_WIDTH);
        else
            w_used = WU_W'(width_reg);
        h_used = (height_reg < 16'd3) ? 16'd3 : height_reg;
        last_col = ({1'b0, col_reg} == w_used - WU_W'(1));
        last_row = (row_reg == h_used - 16'd1);
        if (chans_reg >= 3'd3)
            gray = W_RED * GRAY_W'(pixel.chan0) + W_GREEN * GRAY_W'(pixel.chan1)
                 + W_BLUE * GRAY_W'(pixel.chan2);
        else
            gray = {pixel.chan0, 8'd0};
        tr = (ABS_W+1)'(rd_two_reg);
        mr = (ABS_W+1)'(rd_one_reg);
        br = (ABS_W+1)'(gray_reg);
        tl = (ABS_W+1)'(win_reg[0]);
        ml = (ABS_W+1)'(win_reg[1]);
        bl = (ABS_W+1)'(win_reg[2]);
        tc = (ABS_W+1)'(win_reg[3]);
        bc = (ABS_W+1)'(win_reg[5]);
        sx = signed'((tr + (mr << 1) + br) - (tl + (ml << 1) + bl));
        sy = signed'((bl + (bc << 1) + br) - (tl + (tc << 1) + tr));
        // One squarer, fed |sx| on the sq_x command and |sy| on the sq_y command.
        sq_in = cmd.sq_y ? ay_reg : ax_reg;
        sq = sq_in * sq_in;
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        mag_wide = root_reg[ROOT_W-1:8];
        status.interior = (row_reg >= 16'd2) && (col_reg >= COL_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chans_reg  <= CHANNELS_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write && cfg_index <= CFG_CHANNEL_COUNT)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                CFG_CHANNEL_COUNT: chans_reg <= cfg_data[CHAN_W-1:0];
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.calc)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 16'd1;
            end
            else
                col_reg <= col_reg + COL_W'(1);
        end
    end

    // Line stores: read at pixel accept, written back in the compute cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            gray_reg   <= gray;
            rd_one_reg <= line_one[col_reg];
            rd_two_reg <= line_two[col_reg];
        end
        if (cmd.calc)
        begin
            line_one[col_reg] <= gray_reg;
            line_two[col_reg] <= rd_one_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= rd_two_reg;
            win_reg[4] <= rd_one_reg;
            win_reg[5] <= gray_reg;
            ax_reg   <= ABS_W'(sx < 0 ? -sx : sx);
            ay_reg   <= ABS_W'(sy < 0 ? -sy : sy);
            ccol_reg <= col_reg - COL_W'(1);
            crow_reg <= row_reg - 16'd1;
            last_reg <= last_col && last_row;
        end
        if (cmd.sq_x)
            sqx_reg <= sq;
        if (cmd.sq_y)
        begin
            rad_reg  <= RAD_W'(sqx_reg) + RAD_W'(sq);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            result_reg.magnitude  <= (mag_wide > 11'd255) ? 8'd255 : mag_wide[7:0];
            result_reg.center_col <= OUT_COL_W'(ccol_reg);
            result_reg.center_row <= crow_reg;
            result_reg.last       <= last_reg;
        end
    end

    assign result = result_reg;

endmodule

/* src/sem_ctrl.sv */
module sem_ctrl import sem_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pixel_valid,
    output logic    pixel_ready,
    output logic    result_valid,
    input  logic    result_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {S_IDLE, S_CALC, S_SQX, S_SQY, S_ROOT, S_HOLD} state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;

    always_comb
    begin
        cmd.accept    = (state_reg == S_IDLE) && pixel_valid;
        cmd.calc      = (state_reg == S_CALC);
        cmd.sq_x      = (state_reg == S_SQX);
        cmd.sq_y      = (state_reg == S_SQY);
        cmd.root_step = (state_reg == S_ROOT);
        cmd.load_out  = (state_reg == S_HOLD) && (!out_valid_reg || result_ready);
    end

    assign pixel_ready  = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (pixel_valid) state_reg <= S_CALC;
                S_CALC: state_reg <= status.interior ? S_SQX : S_IDLE;
                S_SQX:  state_reg <= S_SQY;
                S_SQY:
                begin
                    state_reg <= S_ROOT;
                    step_reg  <= STEP_W'(ROOT_STEPS - 1);
                end
                S_ROOT:
                begin
                    if (step_reg == '0)
                        state_reg <= S_HOLD;
                    else
                        step_reg <= step_reg - STEP_W'(1);
                end
                S_HOLD: if (cmd.load_out) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd)) else $error("more than one datapath command at once");

    a_calc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |-> $past(cmd.accept)) else $error("compute without an accepted pixel");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg) else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten before it was taken");

endmodule

/* src/sobel_edge_magnitude.sv */
// Sobel edge magnitude over a raster-order pixel stream. Each pixel beat is
// turned to gray (weights 77/150/29 for three or more channels, else the
// first channel), two line stores and a 3x3 window form the Sobel X and Y
// sums, and an iterative square root gives the magnitude, saturated at 255.
// Only interior pixels yield a result beat, tagged with the center column
// and row and a last flag on the frame's final interior pixel. One pixel is
// in work at a time: a border pixel goes from acceptance through compute
// and back to idle, an interior pixel through acceptance, compute, the
// squaring of the X and then the Y sum through a single multiplier, the
// one-bit-per-cycle root and loading of the output register. The result
// sits in an output register, so the next pixel is taken while it waits;
// an interior pixel that finishes while that register is still full waits
// for it to be taken. Writing any of the three registers restarts the
// frame at column and row zero; write registers only while the block is idle.
module sobel_edge_magnitude import sem_pkg::*; #(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  pix_in_t               pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pix_out_t              result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Command and status traffic between the sequencer and the datapath.
    cmd_t    cmd;
    status_t status;

    sem_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

/* bench/sobel_edge_magnitude_test.sv */
// Self-checking bench for the Sobel edge magnitude block.
// An initial block fills a backlog of pixel beats, phase by phase, each
// phase under its own image geometry and channel count. A clocked driver
// feeds the backlog to the block in bursts, and a clocked monitor checks
// each result beat against an in-order queue of predicted result beats.
module sobel_edge_magnitude_test;
    import sem_pkg::*;

    localparam int unsigned MAXW = MAX_WIDTH_DEFAULT;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;
    // The one register index that maps to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    pix_in_t               pixel = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    pix_out_t              result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sobel_edge_magnitude u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor state: the bench's own copy of the line stores, the window,
    // the raster position and the three registers.
    logic [GRAY_W-1:0] line_one[MAXW];
    logic [GRAY_W-1:0] line_two[MAXW];
    logic [GRAY_W-1:0] win[6];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned width_reg = WIDTH_RESET;
    int unsigned height_reg = HEIGHT_RESET;
    int unsigned chan_reg = CHANNELS_RESET;

    pix_in_t  pixel_backlog[$];
    pix_out_t magnitude_due[$];

    int unsigned errors = 0;
    longint unsigned cycles = 0;
    logic beat_taken = 1'b0;
    bit   steady = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Floor of the square root, one result bit per pass.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos >>= 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v -= root + bitpos;
                root = (root >> 1) + bitpos;
            end
            else
                root >>= 1;
            bitpos >>= 2;
        end
        return root;
    endfunction

    // Mirror of a register write. Any valid index restarts the frame, while
    // the line stores keep what they hold.
    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_IMAGE_WIDTH:   width_reg = value[IMG_W_W-1:0];
            CFG_IMAGE_HEIGHT:  height_reg = value[ROW_W-1:0];
            CFG_CHANNEL_COUNT: chan_reg = value[CHAN_W-1:0];
            default:           return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    // Work out the result beat, if any, that one accepted pixel causes.
    task automatic predict_pixel(pix_in_t p);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        logic [GRAY_W-1:0] gray;
        int tl, tc, tr, ml, mr, bl, bc, br, sx, sy;
        longint unsigned mag;
        pix_out_t due;
        w = (width_reg < 3) ? 3 : ((width_reg > MAXW) ? MAXW : width_reg);
        h = (height_reg < 3) ? 3 : height_reg;
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        col = col_pos;
        row = row_pos;

        // Three or more channels take the luma weights; fewer use chan0 alone.
        if (chan_reg >= 3)
            gray = 16'(77 * p.chan0 + 150 * p.chan1 + 29 * p.chan2);
        else
            gray = {p.chan0, 8'h00};

        tr = line_two[col];
        mr = line_one[col];
        br = gray;

        // A result only once the lower right neighbor of an interior pixel is in.
        if (row >= 2 && col >= 2)
        begin
            tl = win[0];
            ml = win[1];
            bl = win[2];
            tc = win[3];
            bc = win[5];
            sx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
            sy = (bl + 2 * bc + br) - (tl + 2 * tc + tr);
            if (sx < 0)
                sx = -sx;
            if (sy < 0)
                sy = -sy;
            mag = root_floor(longint'(sx) * sx + longint'(sy) * sy) >> 8;
            due.magnitude = (mag > 255) ? 8'd255 : mag[7:0];
            due.center_col = OUT_COL_W'(col - 1);
            due.center_row = ROW_W'(row - 1);
            due.last = (col == w - 1 && row == h - 1);
            magnitude_due.push_back(due);
        end

        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = tr[GRAY_W-1:0];
        win[4] = mr[GRAY_W-1:0];
        win[5] = gray;
        line_two[col] = line_one[col];
        line_one[col] = gray;

        col_pos = col + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // Register writes happen only while the block is idle, one cycle each.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        apply_register(idx, value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait for the block to go quiet: every pixel taken, every result seen,
    // then a pause long enough for a border pixel still in work.
    task automatic drain();
        while (pixel_backlog.size() != 0 || pixel_valid || magnitude_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned ch);
        logic [4:0] junk;
        junk = 5'($urandom);
        // Upper data bits beyond each register's width must be dropped.
        write_register(CFG_IMAGE_WIDTH, {junk, 11'(w)});
        write_register(CFG_IMAGE_HEIGHT, 16'(h));
        write_register(CFG_CHANNEL_COUNT, {13'($urandom), 3'(ch)});
        // A write to the spare index must leave the frame position alone.
        if ($urandom_range(0, 2) == 0)
            write_register(CFG_SPARE, 16'($urandom));
    endtask

    // Random channel bytes, with the extremes often enough to saturate.
    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_random(int unsigned n);
        pix_in_t p;
        repeat (n)
        begin
            p.chan0 = pick_byte();
            p.chan1 = pick_byte();
            p.chan2 = pick_byte();
            pixel_backlog.push_back(p);
        end
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1, logic [PIX_W-1:0] c2);
        pix_in_t p;
        p.chan0 = c0;
        p.chan1 = c1;
        p.chan2 = c2;
        pixel_backlog.push_back(p);
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned ch, int unsigned n,
                             bit calm);
        set_geometry(w, h, ch);
        steady = calm;
        queue_random(n);
        drain();
    endtask

    // Cycle limit; a hang anywhere ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Monitor: check result beats in order, then predict for the pixel beat
    // accepted at this same edge.
    always @(posedge clk)
    begin
        beat_taken <= pixel_valid && pixel_ready;
        if (rst_n && result_valid && result_ready)
        begin
            if (magnitude_due.size() == 0)
            begin
                $error("result beat with nothing expected: %p", result);
                errors++;
            end
            else
            begin
                pix_out_t due;
                due = magnitude_due.pop_front();
                if (result.magnitude !== due.magnitude)
                begin
                    $error("magnitude: expected %0d, got %0d", due.magnitude, result.magnitude);
                    errors++;
                end
                if (result.center_col !== due.center_col)
                begin
                    $error("center_col: expected %0d, got %0d", due.center_col, result.center_col);
                    errors++;
                end
                if (result.center_row !== due.center_row)
                begin
                    $error("center_row: expected %0d, got %0d", due.center_row, result.center_row);
                    errors++;
                end
                if (result.last !== due.last)
                begin
                    $error("last: expected %0d, got %0d", due.last, result.last);
                    errors++;
                end
            end
        end
        if (rst_n && pixel_valid && pixel_ready)
            predict_pixel(pixel);
    end

    // Driver and receiver. The sender runs in bursts separated by random
    // gaps; the receiver drops ready now and then.
    // In a steady phase neither side idles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!pixel_valid || beat_taken)
            begin
                if (gap_left > 0 && !steady)
                begin
                    pixel_valid <= 1'b0;
                    gap_left--;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    pixel <= pixel_backlog.pop_front();
                    pixel_valid <= 1'b1;
                    gap_left = 0;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    pixel_valid <= 1'b0;
            end
            if (stall_left > 0 && !steady)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = 0;
                if ($urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 30);
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        for (int i = 0; i < MAXW; i++)
        begin
            line_one[i] = '0;
            line_two[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: the smallest color frame, with a hard vertical edge that
        // saturates the magnitude and every channel bit toggling.
        set_geometry(3, 3, 3);
        steady = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            queue_pixel(8'hFF, 8'hFF, 8'hFF);
            queue_pixel(8'h00, 8'h00, 8'h00);
            queue_pixel(8'h00, 8'h00, 8'h00);
        end
        drain();
        // Gray mode: only chan0 counts, the other channels carry noise.
        // Two flat rows, then a horizontal edge in the bottom row.
        set_geometry(3, 3, 1);
        queue_pixel(8'h00, 8'hFF, 8'hAA);
        queue_pixel(8'h00, 8'h55, 8'hFF);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hFF);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hFF);
        queue_pixel(8'hFF, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'h00, 8'h00);
        queue_pixel(8'h01, 8'h00, 8'h00);
        drain();

        // Clamped geometry and odd channel counts: width and height below
        // three, a width beyond the line stores, a channel count of zero
        // and one above four, and the tallest frame stopped partway.
        run_phase(0, 0, 0, 30, 1'b0);
        run_phase(2, 2, 7, 20, 1'b0);
        run_phase(2047, 3, 5, 40, 1'b0);
        run_phase(16, 65535, 4, 60, 1'b1);
        run_phase(640, 480, 2, 50, 1'b0);

        // Random: mostly whole small frames, sometimes cut short by the next
        // register write.
        sent = 0;
        while (sent < 680)
        begin
            w = $urandom_range(3, 10);
            h = $urandom_range(3, 7);
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, w * h - 1);
            run_phase(w, h, $urandom_range(0, 7), n, $urandom_range(0, 4) == 0);
            sent += n;
        end

        if (magnitude_due.size() != 0)
        begin
            $error("%0d expected result beats never arrived", magnitude_due.size());
            errors++;
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
